>>> design/mpd_pkg.sv
// Shared codes for the multi-pattern prefix dispatcher.
// Item kinds, result kinds and status codes; no dependencies.
`default_nettype none

package mpd_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_CONNECT = 2'd1,
    KIND_STREAM  = 2'd2
  } kind_e;

  typedef enum logic {
    RES_REGISTER = 1'b0,
    RES_DISPATCH = 1'b1
  } res_kind_e;

  // Registration status, in falling priority: too long, duplicate, full, ok.
  localparam logic [1:0] REG_OK       = 2'd0;
  localparam logic [1:0] REG_DUP      = 2'd1;
  localparam logic [1:0] REG_FULL     = 2'd2;
  localparam logic [1:0] REG_TOO_LONG = 2'd3;

  // Dispatch status.
  localparam logic [1:0] DSP_FOUND = 2'd0;
  localparam logic [1:0] DSP_NONE  = 2'd1;

endpackage

`default_nettype wire

>>> design/mpd_code_mem.sv
// Code byte store, one word per byte position holding that byte of every entry.
// One lane write port, two registered read ports with bypass of the last write.
`default_nettype none

module mpd_code_mem #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_LEN     = 32
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           we_i,
  input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]         waddr_i,
  input  wire logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] wlane_i,
  input  wire logic [7:0]                                     wdata_i,
  input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]         raddr_a_i,
  input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]         raddr_b_i,
  output logic      [NUM_ENTRIES*8-1:0]                       rdata_a_o,
  output logic      [NUM_ENTRIES*8-1:0]                       rdata_b_o
);

  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int WORD_W = NUM_ENTRIES * 8;

  logic [WORD_W-1:0] mem [MAX_LEN];

  logic [WORD_W-1:0] rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] raddr_a_q, raddr_b_q;
  logic              byp_we_q;
  logic [ADDR_W-1:0] byp_addr_q;
  logic [IDX_W-1:0]  byp_lane_q;
  logic [7:0]        byp_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i][wlane_i*8 +: 8] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q     <= mem[raddr_a_i];
    rd_b_q     <= mem[raddr_b_i];
    raddr_a_q  <= raddr_a_i;
    raddr_b_q  <= raddr_b_i;
    byp_addr_q <= waddr_i;
    byp_lane_q <= wlane_i;
    byp_data_q <= wdata_i;
  end

  // A read in the same cycle as a write to that word sees old data: patch the lane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_we_q <= 1'b0;
    end else begin
      byp_we_q <= we_i;
    end
  end

  always_comb begin
    rdata_a_o = rd_a_q;
    rdata_b_o = rd_b_q;
    if (byp_we_q && (byp_addr_q == raddr_a_q)) begin
      rdata_a_o[byp_lane_q*8 +: 8] = byp_data_q;
    end
    if (byp_we_q && (byp_addr_q == raddr_b_q)) begin
      rdata_b_o[byp_lane_q*8 +: 8] = byp_data_q;
    end
  end

endmodule

`default_nettype wire

>>> design/multi_pattern_prefix_dispatch.sv
// Multi-pattern prefix dispatcher top level: code table, loader and matcher.
// Depends on mpd_pkg and mpd_code_mem.
`default_nettype none

// The block takes one item in every clock cycle; busy_o never rises. A result
// appears on the result ports, marked by done_o, in the cycle right after the
// item that causes it, and the receiver must take it then. Code bytes live in
// a memory with one word per byte position that holds that byte of every
// entry: the loader and the matcher each read one word per item, fetched in
// the previous cycle from the position they will need next, and all entries are
// compared in parallel. The table needs no clearing after reset; entries count
// only once registered. Codes are at most MAX_LEN bytes, up to NUM_ENTRIES of
// them; a match reports found only on an exact, full-length hit.
module multi_pattern_prefix_dispatch #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_LEN     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [15:0] handle_i,
  output logic             done_o,
  output logic             result_kind_o,
  output logic [1:0]       status_o,
  output logic [15:0]      found_handle_o,
  output logic [5:0]       matched_length_o
);

  import mpd_pkg::*;

  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int WORD_W = NUM_ENTRIES * 8;

  // Table and control state
  logic [LEN_W-1:0]       code_len_q [NUM_ENTRIES];
  logic [15:0]            handle_q   [NUM_ENTRIES];
  logic [CNT_W-1:0]       entry_count_q, entry_count_d;
  logic [LEN_W-1:0]       load_len_q, load_len_d;
  logic [NUM_ENTRIES-1:0] eq_mask_q, eq_mask_d;
  logic                   overflow_q, overflow_d;
  logic [NUM_ENTRIES-1:0] alive_q, alive_d;
  logic [LEN_W-1:0]       pos_q, pos_d;
  logic                   matching_q, matching_d;

  // Result register
  logic        done_q, done_d;
  logic        res_kind_q, res_kind_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] handle_res_q, handle_res_d;
  logic [5:0]  mlen_q, mlen_d;

  // Memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, raddr_load, raddr_match;
  logic [WORD_W-1:0] word_load, word_match;

  // Working signals
  logic                   accept;
  logic                   ent_we;
  logic [NUM_ENTRIES-1:0] valid_ent, keep_ent, dup_ent, empty_ent, nonempty_ent;
  logic [NUM_ENTRIES-1:0] cand_ent, fin_ent, remain_ent, hit_vec;
  logic [LEN_W-1:0]       ld_len, pos_next;
  logic [NUM_ENTRIES-1:0] ld_mask;
  logic                   ld_ovf;
  logic [15:0]            sel_handle;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign mem_waddr = load_len_q[ADDR_W-1:0];
  assign pos_next  = pos_q + LEN_W'(1);

  // Prefetch the words that the next loader and matcher items will compare.
  assign raddr_load  = (load_len_d < LEN_W'(MAX_LEN)) ? load_len_d[ADDR_W-1:0] : '0;
  assign raddr_match = (pos_d < LEN_W'(MAX_LEN)) ? pos_d[ADDR_W-1:0] : '0;

  mpd_code_mem #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_LEN     (MAX_LEN)
  ) u_code_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wlane_i   (entry_count_q[IDX_W-1:0]),
    .wdata_i   (data_byte_i),
    .raddr_a_i (raddr_load),
    .raddr_b_i (raddr_match),
    .rdata_a_o (word_load),
    .rdata_b_o (word_match)
  );

  // Per-entry compares, all in parallel
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      valid_ent[e]    = CNT_W'(e) < entry_count_q;
      keep_ent[e]     = (load_len_q < code_len_q[e]) && (word_load[e*8 +: 8] == data_byte_i);
      empty_ent[e]    = valid_ent[e] && (code_len_q[e] == '0);
      nonempty_ent[e] = valid_ent[e] && (code_len_q[e] != '0);
      cand_ent[e]     = alive_q[e] && (pos_q < code_len_q[e]) &&
                        (word_match[e*8 +: 8] == data_byte_i);
      fin_ent[e]      = cand_ent[e] && (code_len_q[e] == pos_next);
      remain_ent[e]   = cand_ent[e] && !fin_ent[e];
    end
  end

  // Loader: take the byte first, then close the code if marked last.
  always_comb begin
    ld_len  = load_len_q;
    ld_mask = eq_mask_q;
    ld_ovf  = overflow_q;
    if (has_byte_i) begin
      if (load_len_q >= LEN_W'(MAX_LEN)) begin
        ld_ovf = 1'b1;
      end else begin
        ld_mask = eq_mask_q & keep_ent;
        ld_len  = load_len_q + LEN_W'(1);
      end
    end
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      dup_ent[e] = ld_mask[e] && valid_ent[e] && (code_len_q[e] == ld_len);
    end
  end

  // First hit wins: connect looks for an empty code, a stream byte for a full match.
  always_comb begin
    hit_vec    = (kind_i == KIND_CONNECT) ? empty_ent : fin_ent;
    sel_handle = '0;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (hit_vec[e]) begin
        sel_handle = handle_q[e];
      end
    end
  end

  always_comb begin
    entry_count_d = entry_count_q;
    load_len_d    = load_len_q;
    eq_mask_d     = eq_mask_q;
    overflow_d    = overflow_q;
    alive_d       = alive_q;
    pos_d         = pos_q;
    matching_d    = matching_q;
    mem_we        = 1'b0;
    ent_we        = 1'b0;
    done_d        = 1'b0;
    res_kind_d    = RES_REGISTER;
    status_d      = REG_OK;
    handle_res_d  = '0;
    mlen_d        = '0;
    if (accept) begin
      case (kind_e'(kind_i))
        KIND_LOAD: begin
          mem_we = has_byte_i && (load_len_q < LEN_W'(MAX_LEN)) &&
                   (entry_count_q < CNT_W'(NUM_ENTRIES));
          if (last_byte_i) begin
            done_d = 1'b1;
            if (ld_ovf) begin
              status_d = REG_TOO_LONG;
            end else if (|dup_ent) begin
              status_d = REG_DUP;
            end else if (entry_count_q >= CNT_W'(NUM_ENTRIES)) begin
              status_d = REG_FULL;
            end else begin
              ent_we        = 1'b1;
              entry_count_d = entry_count_q + CNT_W'(1);
            end
            load_len_d = '0;
            eq_mask_d  = '1;
            overflow_d = 1'b0;
          end else begin
            load_len_d = ld_len;
            eq_mask_d  = ld_mask;
            overflow_d = ld_ovf;
          end
        end
        KIND_CONNECT: begin
          pos_d = '0;
          if (|nonempty_ent) begin
            alive_d    = nonempty_ent;
            matching_d = 1'b1;
          end else begin
            alive_d      = '0;
            matching_d   = 1'b0;
            done_d       = 1'b1;
            res_kind_d   = RES_DISPATCH;
            status_d     = (|empty_ent) ? DSP_FOUND : DSP_NONE;
            handle_res_d = sel_handle;
          end
        end
        KIND_STREAM: begin
          if (matching_q && has_byte_i) begin
            if (|remain_ent) begin
              alive_d = remain_ent;
              pos_d   = pos_next;
            end else begin
              alive_d      = '0;
              pos_d        = '0;
              matching_d   = 1'b0;
              done_d       = 1'b1;
              res_kind_d   = RES_DISPATCH;
              status_d     = (|fin_ent) ? DSP_FOUND : DSP_NONE;
              handle_res_d = sel_handle;
              mlen_d       = 6'(pos_next);
            end
          end
        end
        default: begin
          // drop items of unknown kind
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      load_len_q    <= '0;
      eq_mask_q     <= '1;
      overflow_q    <= 1'b0;
      alive_q       <= '0;
      pos_q         <= '0;
      matching_q    <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      entry_count_q <= entry_count_d;
      load_len_q    <= load_len_d;
      eq_mask_q     <= eq_mask_d;
      overflow_q    <= overflow_d;
      alive_q       <= alive_d;
      pos_q         <= pos_d;
      matching_q    <= matching_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    status_q     <= status_d;
    handle_res_q <= handle_res_d;
    mlen_q       <= mlen_d;
    if (ent_we) begin
      code_len_q[entry_count_q[IDX_W-1:0]] <= ld_len;
      handle_q[entry_count_q[IDX_W-1:0]]   <= handle_i;
    end
  end

  assign done_o           = done_q;
  assign result_kind_o    = res_kind_q;
  assign status_o         = status_q;
  assign found_handle_o   = handle_res_q;
  assign matched_length_o = mlen_q;

endmodule

`default_nettype wire

>>> design/mpd_checker.sv
// Port-level checks for the multi-pattern prefix dispatcher.
// Depends on mpd_pkg; bound to multi_pattern_prefix_dispatch below.
`default_nettype none

module mpd_checker #(
  parameter int MAX_LEN = 32
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        result_kind_o,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] found_handle_o,
  input wire logic [5:0]  matched_length_o
);

  import mpd_pkg::*;

  // A result only follows an accepted transaction.
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result without an accepted transaction");

  a_reg_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_kind_o == RES_REGISTER) |->
      (found_handle_o == 16'd0 && matched_length_o == 6'd0))
    else $error("registration result carries handle or length");

  a_dispatch_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_kind_o == RES_DISPATCH) |->
      ((status_o == DSP_FOUND || status_o == DSP_NONE) &&
       matched_length_o <= 6'(MAX_LEN)))
    else $error("dispatch result out of range");

  a_none_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_kind_o == RES_DISPATCH && status_o == DSP_NONE) |->
      found_handle_o == 16'd0)
    else $error("miss reports a handle");

endmodule

bind multi_pattern_prefix_dispatch mpd_checker #(
  .MAX_LEN (MAX_LEN)
) u_mpd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .result_kind_o    (result_kind_o),
  .status_o         (status_o),
  .found_handle_o   (found_handle_o),
  .matched_length_o (matched_length_o)
);

`default_nettype wire

>>> tb/sv/tb_multi_pattern_prefix_dispatch.sv
// Testbench for multi_pattern_prefix_dispatch: directed and random code loads,
// connect matches and stream bytes, checked against an in-bench table tracker.
// Depends on mpd_pkg and the dispatcher RTL.
`default_nettype none

module tb_multi_pattern_prefix_dispatch;
  timeunit 1ns;
  timeprecision 1ps;

  import mpd_pkg::*;

  localparam int ENTRIES = 16;
  localparam int CODE_MAX = 32;
  localparam int ITEM_GOAL = 1250;
  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    res_kind_e rk;
    logic [1:0] st;
    logic [15:0] hnd;
    logic [5:0] mlen;
  } answer_t;

  // Tracks the code table and the running match; queues the answers they imply.
  class code_table_tracker;
    logic [7:0] code_bytes[ENTRIES][CODE_MAX];
    int unsigned code_len[ENTRIES];
    logic [15:0] code_handle[ENTRIES];
    int unsigned n_codes;
    int unsigned load_len;
    int unsigned match_pos;
    logic [ENTRIES-1:0] load_eq;
    logic [ENTRIES-1:0] alive;
    bit load_ovf;
    bit in_match;
    answer_t pending_answers[$];
    int unsigned errors;
    int unsigned reg_seen[4];
    int unsigned found_seen;
    int unsigned none_seen;

    function new();
      n_codes = 0;
      load_len = 0;
      match_pos = 0;
      load_eq = '1;
      alive = '0;
      load_ovf = 0;
      in_match = 0;
      errors = 0;
      found_seen = 0;
      none_seen = 0;
      foreach (reg_seen[i]) reg_seen[i] = 0;
    endfunction

    function void push_answer(res_kind_e rk, logic [1:0] st, logic [15:0] h, logic [5:0] l);
      answer_t a;
      a.rk = rk;
      a.st = st;
      a.hnd = h;
      a.mlen = l;
      pending_answers = {pending_answers, a};
    endfunction

    function void absorb_code_byte(logic [7:0] b);
      if (load_len >= CODE_MAX) begin
        load_ovf = 1;
        return;
      end
      for (int e = 0; e < n_codes; e++)
        if (!(load_len < code_len[e] && code_bytes[e][load_len] == b)) load_eq[e] = 1'b0;
      if (n_codes < ENTRIES) code_bytes[n_codes][load_len] = b;
      load_len++;
    endfunction

    function void close_code(logic [15:0] h);
      bit dup;
      logic [1:0] st;
      dup = 0;
      for (int e = 0; e < n_codes; e++)
        if (load_eq[e] && code_len[e] == load_len) dup = 1;
      if (load_ovf) st = REG_TOO_LONG;
      else if (dup) st = REG_DUP;
      else if (n_codes >= ENTRIES) st = REG_FULL;
      else begin
        st = REG_OK;
        code_len[n_codes] = load_len;
        code_handle[n_codes] = h;
        n_codes++;
      end
      load_len = 0;
      load_eq = '1;
      load_ovf = 0;
      push_answer(RES_REGISTER, st, 16'h0, 6'd0);
    endfunction

    function void open_match();
      logic [ENTRIES-1:0] live;
      bit hit;
      logic [15:0] h;
      live = '0;
      hit = 0;
      h = '0;
      for (int e = 0; e < n_codes; e++) begin
        if (code_len[e] > 0) live[e] = 1'b1;
        else if (!hit) begin
          hit = 1;
          h = code_handle[e];
        end
      end
      match_pos = 0;
      if (live != '0) begin
        alive = live;
        in_match = 1;
      end else begin
        alive = '0;
        in_match = 0;
        push_answer(RES_DISPATCH, hit ? DSP_FOUND : DSP_NONE, hit ? h : 16'h0, 6'd0);
      end
    endfunction

    function void advance_match(logic [7:0] b);
      logic [ENTRIES-1:0] remain;
      bit hit;
      logic [15:0] h;
      int unsigned consumed;
      remain = '0;
      hit = 0;
      h = '0;
      consumed = match_pos + 1;
      for (int e = 0; e < ENTRIES; e++) begin
        if (!alive[e]) continue;
        if (match_pos >= code_len[e] || match_pos >= CODE_MAX) continue;
        if (code_bytes[e][match_pos] != b) continue;
        if (code_len[e] == consumed) begin
          if (!hit) begin
            hit = 1;
            h = code_handle[e];
          end
        end else remain[e] = 1'b1;
      end
      if (remain != '0) begin
        alive = remain;
        match_pos = consumed;
      end else begin
        alive = '0;
        match_pos = 0;
        in_match = 0;
        push_answer(RES_DISPATCH, hit ? DSP_FOUND : DSP_NONE, hit ? h : 16'h0,
                    6'(consumed));
      end
    endfunction

    // Returns 1 when the transaction changes state or causes an answer.
    function bit take_item(logic [1:0] kind, logic [7:0] b, logic has, logic last,
                           logic [15:0] h);
      case (kind)
        KIND_LOAD: begin
          if (has) absorb_code_byte(b);
          if (last) close_code(h);
          return has || last;
        end
        KIND_CONNECT: begin
          open_match();
          return 1;
        end
        KIND_STREAM: begin
          if (!in_match || !has) return 0;
          advance_match(b);
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void check_result(logic rk, logic [1:0] st, logic [15:0] h, logic [5:0] l);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $error("result with no answer pending: kind %0d status %0d", rk, st);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (rk !== want.rk) begin
        $error("result_kind: expected %0d, got %0d", want.rk, rk);
        errors++;
      end
      if (st !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, st);
        errors++;
      end
      if (h !== want.hnd) begin
        $error("found_handle: expected 0x%04h, got 0x%04h", want.hnd, h);
        errors++;
      end
      if (l !== want.mlen) begin
        $error("matched_length: expected %0d, got %0d", want.mlen, l);
        errors++;
      end
      if (want.rk == RES_REGISTER) reg_seen[want.st]++;
      else if (want.st == DSP_FOUND) found_seen++;
      else none_seen++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [1:0] kind_i;
  logic [7:0] data_byte_i;
  logic has_byte_i;
  logic last_byte_i;
  logic [15:0] handle_i;
  logic done_o;
  logic result_kind_o;
  logic [1:0] status_o;
  logic [15:0] found_handle_o;
  logic [5:0] matched_length_o;

  code_table_tracker tracker = new();
  int unsigned accepted_items = 0;
  int unsigned taken_items = 0;
  int unsigned idle_cycles = 0;
  int unsigned run_left = 0;
  bit gapless = 0;

  multi_pattern_prefix_dispatch #(
    .NUM_ENTRIES(ENTRIES),
    .MAX_LEN(CODE_MAX)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .kind_i(kind_i),
    .data_byte_i(data_byte_i),
    .has_byte_i(has_byte_i),
    .last_byte_i(last_byte_i),
    .handle_i(handle_i),
    .done_o(done_o),
    .result_kind_o(result_kind_o),
    .status_o(status_o),
    .found_handle_o(found_handle_o),
    .matched_length_o(matched_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check the answer of the previous transaction first, then note this one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(done_o)) begin
        $error("done_o unknown");
        tracker.errors++;
      end
      if (done_o === 1'b1)
        tracker.check_result(result_kind_o, status_o, found_handle_o, matched_length_o);
      if (start_i && busy_o === 1'b0) begin
        accepted_items++;
        if (tracker.take_item(kind_i, data_byte_i, has_byte_i, last_byte_i, handle_i))
          taken_items++;
        idle_cycles = 0;
      end else if (done_o === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] b, input logic has,
                           input logic last, input logic [15:0] h);
    int unsigned gap;
    if (run_left == 0) begin
      run_left = $urandom_range(20, 80);
      gapless = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    gap = gapless ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i = kind;
    data_byte_i = b;
    has_byte_i = has;
    last_byte_i = last;
    handle_i = h;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every pending answer has come back.
  task automatic drain();
    start_i = 1'b0;
    do @(negedge clk_i); while (tracker.pending_answers.size() != 0);
  endtask

  task automatic register_code(input logic [7:0] bytes[$], input logic [15:0] h,
                               input bit split);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(KIND_LOAD, 8'($urandom), 1'b0, 1'b0, 16'($urandom));
      send_item(KIND_LOAD, bytes[i], 1'b1, !split && i == bytes.size() - 1,
                (!split && i == bytes.size() - 1) ? h : 16'($urandom));
    end
    if (split || bytes.size() == 0) send_item(KIND_LOAD, 8'($urandom), 1'b0, 1'b1, h);
  endtask

  // Small alphabet half the time so codes share prefixes and collide.
  function automatic logic [7:0] pick_byte();
    logic [7:0] alphabet[4];
    alphabet = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    if ($urandom_range(0, 1) == 0) return alphabet[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  task automatic random_code();
    logic [7:0] code[$];
    int unsigned r;
    int unsigned len;
    int unsigned base;
    r = $urandom_range(0, 99);
    if (r < 5) len = 0;
    else if (r < 65) len = $urandom_range(1, 4);
    else if (r < 80) len = $urandom_range(5, CODE_MAX - 1);
    else if (r < 88) len = CODE_MAX;
    else len = $urandom_range(CODE_MAX + 1, CODE_MAX + 4);
    base = ENTRIES;
    if (tracker.n_codes > 0 && $urandom_range(0, 9) < 4)
      base = $urandom_range(0, tracker.n_codes - 1);
    for (int p = 0; p < len; p++) begin
      if (base < ENTRIES && p < tracker.code_len[base])
        code = {code, tracker.code_bytes[base][p]};
      else code = {code, pick_byte()};
    end
    register_code(code, 16'($urandom), $urandom_range(0, 6) == 0);
  endtask

  task automatic stray_item();
    send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
              $urandom_range(0, 4) == 0, 16'($urandom));
  endtask

  task automatic match_sequence();
    logic [7:0] plan[$];
    int unsigned live_idx[$];
    int unsigned e;
    int unsigned r;
    int unsigned cut;
    send_item(KIND_CONNECT, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    if (!tracker.in_match) return;
    for (int i = 0; i < tracker.n_codes; i++)
      if (tracker.code_len[i] > 0) live_idx = {live_idx, i};
    e = live_idx[$urandom_range(0, live_idx.size() - 1)];
    for (int p = 0; p < tracker.code_len[e]; p++) plan = {plan, tracker.code_bytes[e][p]};
    r = $urandom_range(0, 99);
    if (r < 20) plan[$urandom_range(0, plan.size() - 1)] = pick_byte();
    else if (r < 35 && plan.size() > 1) begin
      // Leave the match open; the next connect drops it.
      cut = $urandom_range(1, plan.size() - 1);
      while (plan.size() > cut) void'(plan.pop_back());
    end else if (r < 50) repeat ($urandom_range(1, 4)) plan = {plan, pick_byte()};
    for (int i = 0; i < plan.size(); i++) begin
      if (!tracker.in_match) break;
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: send_item(KIND_STREAM, 8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
          1: send_item(KIND_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
          2: send_item(KIND_LOAD, pick_byte(), 1'b1, 1'b0, 16'($urandom));
          default: send_item(KIND_LOAD, pick_byte(), 1'($urandom), 1'b1, 16'($urandom));
        endcase
      end
      send_item(KIND_STREAM, plan[i], 1'b1, 1'b0, 16'($urandom));
    end
  endtask

  initial begin
    logic [7:0] code[$];
    int unsigned r;
    int unsigned seqs;
    rst_ni = 1'b0;
    start_i = 1'b0;
    kind_i = KIND_LOAD;
    data_byte_i = 8'h00;
    has_byte_i = 1'b0;
    last_byte_i = 1'b0;
    handle_i = 16'h0000;
    seqs = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty table: connect answers at once, stray stream byte and empty load are dropped.
    send_item(KIND_CONNECT, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'hFF, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_LOAD, 8'hFF, 1'b0, 1'b0, 16'hFFFF);
    code = {};
    register_code(code, 16'hA5C3, 1'b0);
    send_item(KIND_CONNECT, 8'hFF, 1'b1, 1'b1, 16'hFFFF);
    register_code(code, 16'h1234, 1'b0);
    code = {8'h00, 8'hFF};
    register_code(code, 16'hFFFF, 1'b0);
    code = {8'h00};
    register_code(code, 16'h0000, 1'b1);
    // Full hit on the longer code, then a miss with no fallback to the shorter one.
    send_item(KIND_CONNECT, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'h00, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'hFF, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_CONNECT, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'h00, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'h12, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_CONNECT, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'hAB, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_UNUSED, 8'hFF, 1'b1, 1'b1, 16'hFFFF);
    // Restart a match, load a duplicate in the middle of it, then finish it.
    send_item(KIND_CONNECT, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_item(KIND_CONNECT, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_item(KIND_STREAM, 8'h00, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_LOAD, 8'h00, 1'b1, 1'b0, 16'h0000);
    send_item(KIND_LOAD, 8'hFF, 1'b1, 1'b1, 16'h5555);
    send_item(KIND_STREAM, 8'hFF, 1'b1, 1'b0, 16'h0000);
    code = {8'h55};
    register_code(code, 16'h8001, 1'b0);
    drain();

    while (taken_items < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 30) random_code();
      else if (r < 88) match_sequence();
      else repeat ($urandom_range(1, 3)) stray_item();
      seqs++;
      if (seqs % 150 == 0) drain();
    end

    start_i = 1'b0;
    while (tracker.pending_answers.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Run: %0d transactions (%0d not ignored), %0d codes stored", accepted_items,
             taken_items, tracker.n_codes);
    $display("Registrations ok/dup/full/too long %0d/%0d/%0d/%0d; dispatch found %0d, none %0d",
             tracker.reg_seen[REG_OK], tracker.reg_seen[REG_DUP], tracker.reg_seen[REG_FULL],
             tracker.reg_seen[REG_TOO_LONG], tracker.found_seen, tracker.none_seen);
    if (tracker.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

>>> multi_pattern_prefix_dispatch.f
design/mpd_pkg.sv
design/mpd_code_mem.sv
design/multi_pattern_prefix_dispatch.sv
design/mpd_checker.sv
tb/sv/tb_multi_pattern_prefix_dispatch.sv
